/* sv/atdf_pkg.sv */
// ----------------------------------------------------------------------------
// atdf_pkg
// Shared types, range codes and constant-divide helper for the autorange
// timer display formatter.
// ----------------------------------------------------------------------------
package atdf_pkg;

    localparam int unsigned MAX_MINUTES = 999;
    localparam int unsigned MAX_SECONDS = 59;
    localparam int unsigned MAX_MILLIS  = 999;

    // reciprocal of ten, exact for every value below 1029
    localparam int unsigned DIV10_MUL   = 205;
    localparam int unsigned DIV10_SHIFT = 11;

    // display range codes
    typedef enum logic [2:0] {
        RNG_MMM  = 3'd0,
        RNG_MM_S = 3'd1,
        RNG_M_SS = 3'd2,
        RNG_SS_T = 3'd3,
        RNG_S_TT = 3'd4,
        RNG_TTT  = 3'd5
    } t_range;

    // control that travels with each pipeline stage
    typedef struct packed {
        logic   valid;
        t_range range;
    } t_stage_ctl;

    // saturated timer value
    typedef struct packed {
        logic [9:0] minutes;
        logic [5:0] seconds;
        logic [9:0] millis;
    } t_time;

    // all decimal digits of the timer value
    typedef struct packed {
        logic [3:0] min_hund;
        logic [3:0] min_tens;
        logic [3:0] min_units;
        logic [3:0] sec_tens;
        logic [3:0] sec_units;
        logic [3:0] ms_hund;
        logic [3:0] ms_tens;
        logic [3:0] ms_units;
    } t_digits;

    // divide by ten through a constant multiply, valid for n below 1029
    function automatic logic [9:0] div10(input logic [9:0] n);
        logic [20:0] prod;
        prod = {11'd0, n} * 21'(DIV10_MUL);
        return prod[DIV10_SHIFT +: 10];
    endfunction

    // remainder after div10, always a single decimal digit
    function automatic logic [3:0] rem10(input logic [9:0] n, input logic [9:0] q);
        logic [9:0] diff;
        diff = n - 10'(q * 10'd10);
        return diff[3:0];
    endfunction

endpackage

/* sv/atdf_clamp.sv */
// ----------------------------------------------------------------------------
// atdf_clamp
// First stage: saturates the timer fields and chooses the display range.
// ----------------------------------------------------------------------------
module atdf_clamp
    import atdf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [9:0] i_minutes,
    input  logic [5:0] i_seconds,
    input  logic [9:0] i_milliseconds,
    output t_stage_ctl o_ctl,
    output t_time      o_time
);

    t_stage_ctl r_ctl, n_ctl;
    t_time      r_time, n_time;

    // saturate each field
    always_comb begin
        n_time.minutes = (i_minutes > 10'(MAX_MINUTES)) ? 10'(MAX_MINUTES) : i_minutes;
        n_time.seconds = (i_seconds > 6'(MAX_SECONDS)) ? 6'(MAX_SECONDS) : i_seconds;
        n_time.millis  = (i_milliseconds > 10'(MAX_MILLIS)) ? 10'(MAX_MILLIS)
                                                             : i_milliseconds;
    end

    // first matching range wins
    always_comb begin
        n_ctl.valid = i_valid;
        if (n_time.minutes >= 10'd100) begin
            n_ctl.range = RNG_MMM;
        end else if (n_time.minutes >= 10'd10) begin
            n_ctl.range = RNG_MM_S;
        end else if (n_time.minutes != 10'd0) begin
            n_ctl.range = RNG_M_SS;
        end else if (n_time.seconds >= 6'd10) begin
            n_ctl.range = RNG_SS_T;
        end else if (n_time.seconds != 6'd0) begin
            n_ctl.range = RNG_S_TT;
        end else begin
            n_ctl.range = RNG_TTT;
        end
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else begin
            r_ctl.valid <= n_ctl.valid;
        end
        r_ctl.range <= n_ctl.range;
        r_time      <= n_time;
    end

    assign o_ctl  = r_ctl;
    assign o_time = r_time;

endmodule

/* sv/atdf_split.sv */
// ----------------------------------------------------------------------------
// atdf_split
// Second stage: splits minutes, seconds and milliseconds into decimal digits.
// ----------------------------------------------------------------------------
module atdf_split
    import atdf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_stage_ctl i_ctl,
    input  t_time      i_time,
    output t_stage_ctl o_ctl,
    output t_digits    o_digits
);

    t_stage_ctl r_ctl;
    t_digits    r_digits, n_digits;

    logic [9:0] min_q1, min_q2;
    logic [9:0] sec_ext, sec_q1;
    logic [9:0] ms_q1, ms_q2;

    // repeated divide by ten
    always_comb begin
        min_q1  = div10(i_time.minutes);
        min_q2  = div10(min_q1);
        sec_ext = {4'd0, i_time.seconds};
        sec_q1  = div10(sec_ext);
        ms_q1   = div10(i_time.millis);
        ms_q2   = div10(ms_q1);

        n_digits.min_units = rem10(i_time.minutes, min_q1);
        n_digits.min_tens  = rem10(min_q1, min_q2);
        n_digits.min_hund  = min_q2[3:0];
        n_digits.sec_units = rem10(sec_ext, sec_q1);
        n_digits.sec_tens  = sec_q1[3:0];
        n_digits.ms_units  = rem10(i_time.millis, ms_q1);
        n_digits.ms_tens   = rem10(ms_q1, ms_q2);
        n_digits.ms_hund   = ms_q2[3:0];
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else begin
            r_ctl.valid <= i_ctl.valid;
        end
        r_ctl.range <= i_ctl.range;
        r_digits    <= n_digits;
    end

    assign o_ctl    = r_ctl;
    assign o_digits = r_digits;

endmodule

/* sv/atdf_select.sv */
// ----------------------------------------------------------------------------
// atdf_select
// Third stage: places digits and decimal points for the chosen range.
// ----------------------------------------------------------------------------
module atdf_select
    import atdf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_stage_ctl i_ctl,
    input  t_digits    i_digits,
    output logic       o_done,
    output logic [3:0] o_digit_left,
    output logic [3:0] o_digit_middle,
    output logic [3:0] o_digit_right,
    output logic       o_dot_left,
    output logic       o_dot_middle,
    output logic [2:0] o_range_code
);

    logic       r_done;
    logic [3:0] r_dl, r_dm, r_dr, n_dl, n_dm, n_dr;
    logic       r_pl, r_pm, n_pl, n_pm;
    t_range     r_range;

    // digit placement by range
    always_comb begin
        n_pl = 1'b0;
        n_pm = 1'b0;
        case (i_ctl.range)
            RNG_MMM: begin
                n_dl = i_digits.min_hund;
                n_dm = i_digits.min_tens;
                n_dr = i_digits.min_units;
            end
            RNG_MM_S: begin
                n_dl = i_digits.min_tens;
                n_dm = i_digits.min_units;
                n_dr = i_digits.sec_tens;
                n_pm = 1'b1;
            end
            RNG_M_SS: begin
                n_dl = i_digits.min_units;
                n_dm = i_digits.sec_tens;
                n_dr = i_digits.sec_units;
                n_pl = 1'b1;
            end
            RNG_SS_T: begin
                n_dl = i_digits.sec_tens;
                n_dm = i_digits.sec_units;
                n_dr = i_digits.ms_hund;
                n_pm = 1'b1;
            end
            RNG_S_TT: begin
                n_dl = i_digits.sec_units;
                n_dm = i_digits.ms_hund;
                n_dr = i_digits.ms_tens;
                n_pl = 1'b1;
            end
            default: begin
                n_dl = i_digits.ms_hund;
                n_dm = i_digits.ms_tens;
                n_dr = i_digits.ms_units;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_ctl.valid;
        end
        r_dl    <= n_dl;
        r_dm    <= n_dm;
        r_dr    <= n_dr;
        r_pl    <= n_pl;
        r_pm    <= n_pm;
        r_range <= i_ctl.range;
    end

    assign o_done         = r_done;
    assign o_digit_left   = r_dl;
    assign o_digit_middle = r_dm;
    assign o_digit_right  = r_dr;
    assign o_dot_left     = r_pl;
    assign o_dot_middle   = r_pm;
    assign o_range_code   = r_range;

endmodule

/* sv/autorange_timer_display_format_unit.sv */
// ----------------------------------------------------------------------------
// autorange_timer_display_format_unit
// Formats a countdown timer value into three digits and two decimal points.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on each rising edge with i_start high and o_busy low.
//   o_busy is always low, so a new timer value may be given every cycle.
//   Each request carries minutes, seconds and milliseconds; out-of-range
//   fields saturate (999 minutes, 59 seconds, 999 milliseconds).
//   The result passes the clamp, split and select registers in that order and
//   is then on the digit, dot and range ports, marked by o_done.
//   Throughput is one request per cycle, with three register stages:
//   saturate and classify, decimal split, placement.
//   The receiver cannot stall; every result must be captured when o_done
//   is high.
//   Synchronous reset clears the stage valid bits, so no result is produced
//   for requests still in flight; the datapath holds no other state.
// ----------------------------------------------------------------------------
module autorange_timer_display_format_unit
    import atdf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    output logic       o_busy,
    input  logic [9:0] i_minutes,
    input  logic [5:0] i_seconds,
    input  logic [9:0] i_milliseconds,
    output logic       o_done,
    output logic [3:0] o_digit_left,
    output logic [3:0] o_digit_middle,
    output logic [3:0] o_digit_right,
    output logic       o_dot_left,
    output logic       o_dot_middle,
    output logic [2:0] o_range_code
);

    t_stage_ctl s1_ctl, s2_ctl;
    t_time      s1_time;
    t_digits    s2_digits;
    logic       accept;

    // fully pipelined, never busy
    assign o_busy = 1'b0;
    assign accept = i_start && !o_busy;

    // saturate and classify
    atdf_clamp u_clamp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (accept),
        .i_minutes      (i_minutes),
        .i_seconds      (i_seconds),
        .i_milliseconds (i_milliseconds),
        .o_ctl          (s1_ctl),
        .o_time         (s1_time)
    );

    // decimal split
    atdf_split u_split (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (s1_ctl),
        .i_time   (s1_time),
        .o_ctl    (s2_ctl),
        .o_digits (s2_digits)
    );

    // digit placement
    atdf_select u_select (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (s2_ctl),
        .i_digits       (s2_digits),
        .o_done         (o_done),
        .o_digit_left   (o_digit_left),
        .o_digit_middle (o_digit_middle),
        .o_digit_right  (o_digit_right),
        .o_dot_left     (o_dot_left),
        .o_dot_middle   (o_dot_middle),
        .o_range_code   (o_range_code)
    );

    // every accepted request gives a result on o_done
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##3 o_done)
        else $error("result missing three cycles after request");

    // no result without a matching earlier request
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, 3))
        else $error("result without matching request");

    // at most one decimal point lit
    a_one_dot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_dot_left && o_dot_middle))
        else $error("both decimal points lit");

    // left dot only in the M.SS and S.tt ranges
    a_left_dot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_dot_left) |-> (o_range_code == RNG_M_SS || o_range_code == RNG_S_TT))
        else $error("left dot lit in wrong range");

    // minutes of one hundred or more always give the hundreds-of-minutes range
    a_mmm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_minutes >= 10'd100) |-> ##3 (o_range_code == RNG_MMM))
        else $error("large minute value not shown in minute range");

endmodule

/* dv/autorange_timer_display_format_unit_test.sv */
// ----------------------------------------------------------------------------
// autorange_timer_display_format_unit_test
// Drives timer values into the display formatter with random gaps, predicts
// the digits, dots and range code of each request, and compares every
// result strobe against the oldest pending prediction.
// ----------------------------------------------------------------------------
module autorange_timer_display_format_unit_test;
    import atdf_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 1800;
    localparam int DRAIN_CYCLES  = 8;
    localparam int REPORT_LIMIT  = 10;

    // one predicted display frame
    typedef struct {
        logic [3:0] left;
        logic [3:0] middle;
        logic [3:0] right;
        logic       dot_l;
        logic       dot_m;
        t_range     code;
    } t_display;

    // prediction of display frames and comparison against the outputs
    class display_tracker;
        t_display    frames_q[$];
        int unsigned errors;

        function t_display format_display(logic [9:0] m, logic [5:0] s, logic [9:0] ms);
            int unsigned mn, sc, ml;
            t_display d;
            mn = (m > MAX_MINUTES) ? MAX_MINUTES : m;
            sc = (s > MAX_SECONDS) ? MAX_SECONDS : s;
            ml = (ms > MAX_MILLIS) ? MAX_MILLIS : ms;
            d.dot_l = 1'b0;
            d.dot_m = 1'b0;
            if (mn >= 100) begin
                d.code   = RNG_MMM;
                d.left   = 4'(mn / 100);
                d.middle = 4'((mn % 100) / 10);
                d.right  = 4'(mn % 10);
            end else if (mn >= 10) begin
                d.code   = RNG_MM_S;
                d.left   = 4'(mn / 10);
                d.middle = 4'(mn % 10);
                d.right  = 4'(sc / 10);
                d.dot_m  = 1'b1;
            end else if (mn > 0) begin
                d.code   = RNG_M_SS;
                d.left   = 4'(mn);
                d.middle = 4'(sc / 10);
                d.right  = 4'(sc % 10);
                d.dot_l  = 1'b1;
            end else if (sc >= 10) begin
                d.code   = RNG_SS_T;
                d.left   = 4'(sc / 10);
                d.middle = 4'(sc % 10);
                d.right  = 4'(ml / 100);
                d.dot_m  = 1'b1;
            end else if (sc > 0) begin
                d.code   = RNG_S_TT;
                d.left   = 4'(sc);
                d.middle = 4'(ml / 100);
                d.right  = 4'((ml % 100) / 10);
                d.dot_l  = 1'b1;
            end else begin
                d.code   = RNG_TTT;
                d.left   = 4'(ml / 100);
                d.middle = 4'((ml % 100) / 10);
                d.right  = 4'(ml % 10);
            end
            return d;
        endfunction

        function void note_request(logic [9:0] m, logic [5:0] s, logic [9:0] ms);
            frames_q.push_back(format_display(m, s, ms));
        endfunction

        function int pending();
            return frames_q.size();
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= REPORT_LIMIT) $display("%s", msg);
        endfunction

        function void check_result(logic [3:0] dl, logic [3:0] dm, logic [3:0] dr,
                                   logic pl, logic pm, logic [2:0] rc);
            t_display want;
            if (frames_q.size() == 0) begin
                flag($sformatf("unexpected result L%0d M%0d R%0d dots %b%b range %0d",
                               dl, dm, dr, pl, pm, rc));
                return;
            end
            want = frames_q.pop_front();
            if (want.left !== dl || want.middle !== dm || want.right !== dr ||
                want.dot_l !== pl || want.dot_m !== pm || want.code !== rc) begin
                flag($sformatf({"expected L%0d M%0d R%0d dots %b%b range %0d,",
                                " got L%0d M%0d R%0d dots %b%b range %0d"},
                               want.left, want.middle, want.right, want.dot_l,
                               want.dot_m, want.code, dl, dm, dr, pl, pm, rc));
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_start = 1'b0;
    logic [9:0] i_minutes = '0;
    logic [5:0] i_seconds = '0;
    logic [9:0] i_milliseconds = '0;
    logic       o_busy;
    logic       o_done;
    logic [3:0] o_digit_left;
    logic [3:0] o_digit_middle;
    logic [3:0] o_digit_right;
    logic       o_dot_left;
    logic       o_dot_middle;
    logic [2:0] o_range_code;

    display_tracker tracker = new();
    int unsigned    cycle_count = 0;
    bit             gaps_on = 1'b1;

    autorange_timer_display_format_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_minutes      (i_minutes),
        .i_seconds      (i_seconds),
        .i_milliseconds (i_milliseconds),
        .o_done         (o_done),
        .o_digit_left   (o_digit_left),
        .o_digit_middle (o_digit_middle),
        .o_digit_right  (o_digit_right),
        .o_dot_left     (o_dot_left),
        .o_dot_middle   (o_dot_middle),
        .o_range_code   (o_range_code)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("autorange_timer_display_format_unit: mismatch");
            $finish;
        end
    end

    // results are stable mid-cycle, sample them there
    always @(negedge i_clk) begin
        if (i_rst_n && o_done === 1'b1)
            tracker.check_result(o_digit_left, o_digit_middle, o_digit_right,
                                 o_dot_left, o_dot_middle, o_range_code);
    end

    // present one request and hold it until the block takes it
    task automatic send_request(logic [9:0] m, logic [5:0] s, logic [9:0] ms);
        i_start        <= 1'b1;
        i_minutes      <= m;
        i_seconds      <= s;
        i_milliseconds <= ms;
        do @(negedge i_clk); while (o_busy !== 1'b0);
        @(posedge i_clk);
        tracker.note_request(m, s, ms);
    endtask

    // random idle time between requests, mostly short
    task automatic idle_gap();
        int unsigned pick, len;
        pick = $urandom_range(99);
        if (!gaps_on || pick < 55) len = 0;
        else if (pick < 88) len = $urandom_range(3, 1);
        else if (pick < 97) len = $urandom_range(12, 4);
        else len = $urandom_range(60, 20);
        if (len > 0) begin
            i_start <= 1'b0;
            repeat (len) @(posedge i_clk);
        end
    endtask

    // hold off until every pending frame has come back
    task automatic drain_results();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() > 0) @(posedge i_clk);
    endtask

    // random timer value, usually aimed at one range, other fields at full width
    task automatic pick_timer(output logic [9:0] m, output logic [5:0] s,
                              output logic [9:0] ms);
        int unsigned sel;
        sel = $urandom_range(6);
        m  = 10'($urandom_range(1023));
        s  = 6'($urandom_range(63));
        ms = 10'($urandom_range(1023));
        case (sel)
            0: m = 10'($urandom_range(1023, 100));
            1: m = 10'($urandom_range(99, 10));
            2: m = 10'($urandom_range(9, 1));
            3: begin
                m = '0;
                s = 6'($urandom_range(63, 10));
            end
            4: begin
                m = '0;
                s = 6'($urandom_range(9, 1));
            end
            5: begin
                m = '0;
                s = '0;
            end
            default: ;
        endcase
    endtask

    // stimulus
    initial begin
        logic [9:0] m;
        logic [5:0] s;
        logic [9:0] ms;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: range boundaries, saturation and leading zeros
        gaps_on = 1'b0;
        send_request(10'd0,    6'd0,  10'd0);
        send_request(10'd1023, 6'd63, 10'd1023);
        send_request(10'd999,  6'd59, 10'd999);
        send_request(10'd1000, 6'd0,  10'd0);
        send_request(10'd100,  6'd0,  10'd0);
        send_request(10'd99,   6'd59, 10'd0);
        send_request(10'd10,   6'd7,  10'd500);
        send_request(10'd9,    6'd59, 10'd999);
        send_request(10'd1,    6'd0,  10'd0);
        send_request(10'd1,    6'd63, 10'd0);
        send_request(10'd0,    6'd63, 10'd1023);
        send_request(10'd0,    6'd60, 10'd5);
        send_request(10'd0,    6'd59, 10'd999);
        send_request(10'd0,    6'd10, 10'd0);
        send_request(10'd0,    6'd9,  10'd999);
        send_request(10'd0,    6'd1,  10'd1000);
        send_request(10'd0,    6'd1,  10'd90);
        send_request(10'd0,    6'd0,  10'd7);
        send_request(10'd0,    6'd0,  10'd1023);
        send_request(10'd0,    6'd0,  10'd999);
        send_request(10'd0,    6'd0,  10'd1000);
        send_request(10'd512,  6'd32, 10'd512);
        send_request(10'd0,    6'd0,  10'd1);
        drain_results();

        // random requests in phases, gaps on or off per phase
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 200 == 0) gaps_on = ($urandom_range(3) != 0);
            if (i % 450 == 449) drain_results();
            pick_timer(m, s, ms);
            send_request(m, s, ms);
            idle_gap();
        end

        // wait for the tail, then wait DRAIN_CYCLES for anything stray
        i_start <= 1'b0;
        while (tracker.pending() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (tracker.pending() > 0)
            tracker.flag($sformatf("%0d expected frames never arrived", tracker.pending()));

        if (tracker.errors == 0)
            $display("autorange_timer_display_format_unit: match");
        else
            $display("autorange_timer_display_format_unit: mismatch");
        $finish;
    end

endmodule
